/* rtl/core/qdd_pkg.sv */
package qdd_pkg;

	localparam int DetentWidth = 7;
	localparam int CountWidth  = 8;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_TAKE  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] CLICK_NONE  = 2'd0;
	localparam logic [1:0] CLICK_RIGHT = 2'd1;
	localparam logic [1:0] CLICK_LEFT  = 2'd2;

	localparam logic signed [CountWidth-1:0] COUNT_MAX = 8'sd127;
	localparam logic signed [CountWidth-1:0] COUNT_MIN = -8'sd127;

	localparam logic [DetentWidth-1:0] DETENT_RESET = 7'd4;

	localparam logic [1:0] REG_STEPS_PER_DETENT = 2'd0;

	// input beat, lowest bit first: operation, pin_a, pin_b
	typedef struct packed {
		logic [3:0] pad;
		logic       pin_b;
		logic       pin_a;
		logic [1:0] operation;
	} in_beat_t;

	// result beat, lowest bit first: notify, click, step_count
	typedef struct packed {
		logic [4:0]                   pad;
		logic signed [CountWidth-1:0] step_count;
		logic [1:0]                   click;
		logic                         notify;
	} res_beat_t;

	typedef struct packed {
		logic                         last_a;
		logic                         last_b;
		logic signed [CountWidth-1:0] steps;
	} qdd_state_t;

	function automatic logic signed [CountWidth-1:0] sat_up(
		input logic signed [CountWidth-1:0] v
	);
		sat_up = (v < COUNT_MAX) ? v + 8'sd1 : v;
	endfunction

	function automatic logic signed [CountWidth-1:0] sat_down(
		input logic signed [CountWidth-1:0] v
	);
		sat_down = (v > COUNT_MIN) ? v - 8'sd1 : v;
	endfunction

endpackage

/* rtl/core/qdd_cfg.sv */
module qdd_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [1:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	output logic [qdd_pkg::DetentWidth-1:0]    detent
);
	import qdd_pkg::*;

	logic [DetentWidth-1:0] spd_q;
	logic                   wr_en;

	// one register, every byte address of the word maps onto it
	assign wr_en  = psel && penable && pwrite && ((paddr >> 2) == REG_STEPS_PER_DETENT);
	assign pready = 1'b1;
	assign prdata = {{(32-DetentWidth){1'b0}}, spd_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_q <= DETENT_RESET;
		end else if (wr_en) begin
			spd_q <= pwdata[DetentWidth-1:0];
		end
	end

	// zero detent counts as one
	assign detent = (spd_q == '0) ? DetentWidth'(1) : spd_q;

endmodule

/* rtl/core/qdd_step.sv */
module qdd_step (
	input  qdd_pkg::in_beat_t                  beat,
	input  qdd_pkg::qdd_state_t                cur,
	input  logic [qdd_pkg::DetentWidth-1:0]    detent,
	output qdd_pkg::qdd_state_t                nxt,
	output qdd_pkg::res_beat_t                 res
);
	import qdd_pkg::*;

	logic                          a_new;
	logic                          b_new;
	logic                          a_chg;
	logic                          b_chg;
	logic signed [CountWidth-1:0]  cnt_a;
	logic signed [CountWidth-1:0]  cnt_ab;
	logic signed [CountWidth:0]    det_s;
	logic signed [CountWidth:0]    cnt_ext;
	logic signed [CountWidth:0]    tick_ext;
	logic                          take_right;
	logic                          take_left;

	assign a_new = ~beat.pin_a;
	assign b_new = ~beat.pin_b;
	assign a_chg = a_new != cur.last_a;
	assign b_chg = b_new != cur.last_b;

	// channel a first, then channel b against the updated a
	always_comb begin
		cnt_a = cur.steps;
		if (a_chg) begin
			cnt_a = (a_new == cur.last_b) ? sat_up(cur.steps) : sat_down(cur.steps);
		end
		cnt_ab = cnt_a;
		if (b_chg) begin
			cnt_ab = (a_new == b_new) ? sat_down(cnt_a) : sat_up(cnt_a);
		end
	end

	assign det_s      = $signed({{(CountWidth+1-DetentWidth){1'b0}}, detent});
	assign cnt_ext    = {cur.steps[CountWidth-1], cur.steps};
	assign tick_ext   = {cnt_ab[CountWidth-1], cnt_ab};
	assign take_right = cnt_ext >= det_s;
	assign take_left  = cnt_ext <= -det_s;

	always_comb begin
		nxt            = cur;
		res            = '0;
		res.step_count = cur.steps;
		case (beat.operation)
			OP_TICK: begin
				nxt.last_a     = a_new;
				nxt.last_b     = b_new;
				nxt.steps      = cnt_ab;
				res.step_count = cnt_ab;
				res.notify     = (a_chg || b_chg) && ((tick_ext >= det_s) || (tick_ext <= -det_s));
			end
			OP_TAKE: begin
				if (take_right) begin
					nxt.steps = CountWidth'(cnt_ext - det_s);
					res.click = CLICK_RIGHT;
				end else if (take_left) begin
					nxt.steps = CountWidth'(cnt_ext + det_s);
					res.click = CLICK_LEFT;
				end
				res.step_count = nxt.steps;
			end
			OP_CLEAR: begin
				nxt.steps      = '0;
				res.step_count = '0;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

/* rtl/core/quadrature_detent_decoder.sv */
// Quadrature detent decoder: each input beat either samples the active-low A/B pins of a rotary
// encoder, takes one pending click (right or left, moving the count back by one detent) or
// clears the count; every input beat yields exactly one result beat with notify, click and the
// saturated step count. Beats are taken at one per cycle while the result side does not stall;
// an input register holds the accepted beat, the step logic updates the count and pin state as
// the beat moves on into the result register, and the result register holds the answer while
// the downstream side stalls. steps_per_detent (address 0) should only be written while no
// beat is in flight.
module quadrature_detent_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // operation[1:0], pin_a[2], pin_b[3], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // notify[0], click[2:1], step_count[10:3], zero pad
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import qdd_pkg::*;

	in_beat_t               in_s1;
	logic                   in_valid_s1;
	res_beat_t              res_s2;
	logic                   res_valid_s2;
	qdd_state_t             state_q;
	qdd_state_t             state_nxt;
	res_beat_t              res_nxt;
	logic [DetentWidth-1:0] detent;
	logic                   adv;
	logic                   load;

	qdd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.detent  (detent)
	);

	qdd_step u_step (
		.beat   (in_s1),
		.cur    (state_q),
		.detent (detent),
		.nxt    (state_nxt),
		.res    (res_nxt)
	);

	assign adv      = in_valid_s1 && (!res_valid_s2 || m_tready);
	assign s_tready = !in_valid_s1 || adv;
	assign load     = s_tvalid && s_tready;
	assign m_tvalid = res_valid_s2;
	assign m_tdata  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			res_valid_s2 <= 1'b0;
			state_q      <= '0;
		end else begin
			if (load) begin
				in_valid_s1 <= 1'b1;
			end else if (adv) begin
				in_valid_s1 <= 1'b0;
			end
			if (adv) begin
				res_valid_s2 <= 1'b1;
				state_q      <= state_nxt;
			end else if (m_tready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			in_s1 <= s_tdata;
		end
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	// count never leaves the saturation range
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 |-> res_s2.step_count != -8'sd128)
		else $error("step count out of range");

	// a beat is never both a click and a notification
	a_click_notify: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_s2.click != CLICK_NONE |-> !res_s2.notify)
		else $error("click and notify together");

	// freshly loaded result carries the count just stored
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_s2.step_count == state_q.steps)
		else $error("result count differs from stored count");

	// an advancing beat always shows up on the result side next cycle
	a_adv_valid: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_valid_s2)
		else $error("advanced beat lost");

endmodule

/* test/tb.sv */
module tb;
	import qdd_pkg::*;

	localparam logic [1:0] OP_SPARE    = 2'd3;
	localparam int         CYCLE_LIMIT = 300000;
	localparam int         PRINT_LIMIT = 200;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;      // operation[1:0], pin_a[2], pin_b[3], zero pad
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;            // notify[0], click[2:1], step_count[10:3], zero pad
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [1:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	quadrature_detent_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #6 clk = ~clk;

	// decoder state as the block should hold it
	logic [DetentWidth-1:0] cfg_detent = DETENT_RESET;
	logic                   cur_a      = 1'b0;
	logic                   cur_b      = 1'b0;
	int                     cur_steps  = 0;

	// pin levels after the last queued tick, used to build rotations
	logic gen_a = 1'b0;
	logic gen_b = 1'b0;

	in_beat_t  encoder_beats[$];
	res_beat_t decoded_due[$];

	int  queued       = 0;
	int  results_seen = 0;
	int  mismatches   = 0;
	int  cycle_count  = 0;
	int  send_wait    = 0;
	int  recv_wait    = 0;
	bit  send_calm    = 1'b0;
	bit  recv_calm    = 1'b1;

	function automatic void nudge_count(input bit up);
		if (up && cur_steps < COUNT_MAX)
			cur_steps++;
		else if (!up && cur_steps > COUNT_MIN)
			cur_steps--;
	endfunction

	function automatic res_beat_t decode_beat(input in_beat_t beat);
		res_beat_t r;
		logic      a;
		logic      b;
		bit        moved;
		int        d;
		r     = '0;
		a     = ~beat.pin_a;
		b     = ~beat.pin_b;
		moved = 1'b0;
		d     = (cfg_detent == 0) ? 1 : int'(cfg_detent);
		case (beat.operation)
			OP_TICK: begin
				if (a != cur_a) begin
					cur_a = a;
					nudge_count(cur_a == cur_b);
					moved = 1'b1;
				end
				if (b != cur_b) begin
					cur_b = b;
					nudge_count(cur_a != cur_b);
					moved = 1'b1;
				end
				r.notify = moved && (cur_steps >= d || cur_steps <= -d);
			end
			OP_TAKE: begin
				if (cur_steps >= d) begin
					cur_steps -= d;
					r.click = CLICK_RIGHT;
				end else if (cur_steps <= -d) begin
					cur_steps += d;
					r.click = CLICK_LEFT;
				end
			end
			OP_CLEAR: begin
				cur_steps = 0;
			end
			default: begin
			end
		endcase
		r.step_count = 8'(cur_steps);
		return r;
	endfunction

	function automatic int pick_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		if (mismatches < PRINT_LIMIT)
			$display("mismatch on result %0d, %s: got %0d, want %0d",
				results_seen, field, got, want);
		mismatches++;
	endtask

	task automatic check_result(input res_beat_t got);
		res_beat_t want;
		if (decoded_due.size() == 0) begin
			report_mismatch("no result outstanding, step_count", got.step_count, 0);
		end else begin
			want = decoded_due.pop_front();
			if (got.notify !== want.notify)
				report_mismatch("notify", got.notify, want.notify);
			if (got.click !== want.click)
				report_mismatch("click", got.click, want.click);
			if (got.step_count !== want.step_count)
				report_mismatch("step_count", got.step_count, want.step_count);
		end
		results_seen++;
	endtask

	task automatic queue_item(input logic [1:0] op, input logic pa, input logic pb);
		in_beat_t beat;
		beat           = '0;
		beat.operation = op;
		beat.pin_a     = pa;
		beat.pin_b     = pb;
		encoder_beats.push_back(beat);
		queued++;
		if (op == OP_TICK) begin
			gen_a = ~pa;
			gen_b = ~pb;
		end
	endtask

	task automatic queue_levels(input logic a, input logic b);
		queue_item(OP_TICK, ~a, ~b);
	endtask

	// one quadrature step in the chosen direction
	task automatic rotate(input bit up);
		if ((gen_a == gen_b) == up)
			queue_levels(gen_a, ~gen_b);
		else
			queue_levels(~gen_a, gen_b);
	endtask

	task automatic fill_phase(input int n);
		int start;
		int len;
		int kind;
		bit up;
		bit fast;
		start = queued;
		while (queued - start < n) begin
			kind = $urandom_range(0, 19);
			if (kind < 13) begin
				up   = 1'($urandom_range(0, 1));
				fast = ($urandom_range(0, 3) == 0);
				len  = ($urandom_range(0, 11) == 0) ? $urandom_range(70, 90)
					: $urandom_range(1, 30);
				repeat (len) begin
					// both channels flipping at once moves two steps
					if (fast)
						queue_levels(~gen_a, ~gen_b);
					else
						rotate(up);
					if (len < 70 && $urandom_range(0, 4) == 0)
						queue_item(OP_TAKE, 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)));
				end
			end else if (kind < 15) begin
				queue_item(OP_TAKE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else if (kind < 16) begin
				queue_item(OP_CLEAR, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else if (kind < 17) begin
				queue_item(OP_SPARE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else if (kind < 18) begin
				queue_levels(gen_a, gen_b);
			end else begin
				queue_item(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic wait_idle;
		do
			@(negedge clk);
		while (encoder_beats.size() != 0 || s_tvalid || decoded_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_detent(input logic [DetentWidth-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_STEPS_PER_DETENT << 2;
		pwdata  <= {{(32-DetentWidth){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_detent = value;
	endtask

	// input beat driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_wait = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				decoded_due.push_back(decode_beat(s_tdata));
				send_wait = pick_wait(send_calm);
				if ($urandom_range(0, 39) == 0)
					send_calm = !send_calm;
			end
			if (!s_tvalid || s_tready) begin
				if (send_wait > 0) begin
					send_wait--;
					s_tvalid <= 1'b0;
				end else if (encoder_beats.size() > 0) begin
					s_tdata  <= encoder_beats.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result beat monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result(m_tdata);
				recv_wait = pick_wait(recv_calm);
				if ($urandom_range(0, 39) == 0)
					recv_calm = !recv_calm;
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			m_tready <= (recv_wait == 0);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		logic [DetentWidth-1:0] detents[8];
		detents = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd100, 7'd7, 7'd4};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, reset detent of four
		queue_levels(gen_a, gen_b);
		queue_item(OP_SPARE, 1'b0, 1'b0);
		repeat (4) rotate(1'b1);
		queue_levels(gen_a, gen_b);
		queue_item(OP_TAKE, 1'b1, 1'b0);
		queue_item(OP_TAKE, 1'b0, 1'b1);
		repeat (2) queue_levels(~gen_a, ~gen_b);
		queue_item(OP_TAKE, 1'b1, 1'b1);
		repeat (3) rotate(1'b0);
		queue_item(OP_CLEAR, 1'b0, 1'b1);
		queue_item(OP_SPARE, 1'b1, 1'b1);
		queue_item(OP_TICK, 1'b0, 1'b0);
		queue_item(OP_TICK, 1'b1, 1'b1);
		fill_phase(50);

		foreach (detents[i]) begin
			wait_idle();
			write_detent(detents[i]);
			fill_phase(55);
		end

		wait_idle();
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
